// File: rtl/core/mqaa_pkg.sv
`timescale 1ns / 1ps
package mqaa_pkg;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_OOM   = 2'd2,
        ST_EMPTY = 2'd3
    } t_status;

    // operation codes of an input transaction
    typedef enum logic {
        OP_ENQ = 1'b0,
        OP_DEQ = 1'b1
    } t_op;

    // register index of queue_capacity
    localparam logic REG_CAP = 1'b0;

    localparam logic [16:0] MAX_ENTRY = 17'd65532;
    localparam logic [31:0] HDR_BYTES = 32'd4;
    localparam logic [31:0] MIN_SPLIT = 32'd8;

    // datapath micro-operations issued by the controller
    typedef enum logic [4:0] {
        A_NONE,
        A_INIT_HDR,
        A_INIT_LNK,
        A_INIT_END,
        A_ACCEPT,
        A_WALK_START,
        A_RD_SIZE,
        A_FIT_SZ,
        A_LOAD_CUR,
        A_MRG_SZ,
        A_MRG_NX,
        A_UNL_CHK,
        A_RELINK,
        A_MRG_WR,
        A_SPLIT1,
        A_SPLIT2,
        A_TAKE_RD,
        A_TAKE_WR,
        A_PUSH,
        A_REFUSE,
        A_OOM,
        A_DQ_SLOT_RD,
        A_DQ_LOADOFF,
        A_DQ_SZ,
        A_DQ_LNK,
        A_DQ_NXT,
        A_DQ_NXR,
        A_FIN
    } t_act;

    // datapath flags seen by the controller
    typedef struct packed {
        logic is_deq;
        logic full;
        logic empty;
        logic too_big;
        logic cur_end;
        logic fits;
        logic nxt_end;
        logic cand;
        logic hit;
        logic split;
        logic out_busy;
    } t_dp_stat;

    // configuration write toward the datapath
    typedef struct packed {
        logic       we;
        logic [7:0] cap;
    } t_cfg_wr;

endpackage

// File: rtl/core/mqaa_if.sv
`timescale 1ns / 1ps
interface mqaa_in_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [15:0] msg_length;

    modport source (output valid, output op, output msg_length, input ready);
    modport sink (input valid, input op, input msg_length, output ready);
endinterface

interface mqaa_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [15:0] entry_offset;
    logic [15:0] entry_size;

    modport source (output valid, output status, output entry_offset, output entry_size,
                    input ready);
    modport sink (input valid, input status, input entry_offset, input entry_size,
                  output ready);
endinterface

// File: rtl/core/message_queue_arena_allocator.sv
`timescale 1ns / 1ps
// enqueue: walks the free list for a first fit, then splits the block or takes it whole;
//   when none fits, merges a free block with a free physical successor, unlinking it,
//   and walks again; dequeue frees the entry and merges it with a free successor;
//   refusals go straight to the result; all bound by the single arena port
// throughput: one transaction in flight; the next is taken once the result is registered
// reset: synchronous active low; after reset S_INIT0, S_INIT1 and S_INIT2 write the initial
//   free block and end marker, during which no transaction is taken
module message_queue_arena_allocator import mqaa_pkg::*; #(
    parameter int ARENA_BYTES = 65536,
    parameter int RING_SLOTS  = 256
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    mqaa_in_if.sink      i_in_ch,
    mqaa_out_if.source   o_out_ch,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    t_act       w_act;
    t_dp_stat   w_stat;
    t_cfg_wr    w_cfg;
    logic [7:0] w_cap;
    logic       w_in_ready;
    logic       w_out_valid;
    logic [1:0] w_out_status;
    logic [15:0] w_out_offset;
    logic [15:0] w_out_size;

    // apb: zero wait states, register index sits in paddr[2]
    assign pready    = 1'b1;
    assign w_cfg.we  = psel && penable && pwrite && (paddr[2] == REG_CAP);
    assign w_cfg.cap = pwdata[7:0];
    assign prdata    = (paddr[2] == REG_CAP) ? {24'd0, w_cap} : 32'd0;

    // sequencer: walk, merge and split steps
    mqaa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_ch.valid),
        .i_stat     (w_stat),
        .o_in_ready (w_in_ready),
        .o_act      (w_act)
    );

    // arena memory, slot ring and result register
    mqaa_dpath #(
        .ARENA_BYTES (ARENA_BYTES),
        .RING_SLOTS  (RING_SLOTS)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_act        (w_act),
        .i_cfg        (w_cfg),
        .i_in_op      (i_in_ch.op),
        .i_in_len     (i_in_ch.msg_length),
        .i_out_ready  (o_out_ch.ready),
        .o_stat       (w_stat),
        .o_cap        (w_cap),
        .o_out_valid  (w_out_valid),
        .o_out_status (w_out_status),
        .o_out_offset (w_out_offset),
        .o_out_size   (w_out_size)
    );

    assign i_in_ch.ready         = w_in_ready;
    assign o_out_ch.valid        = w_out_valid;
    assign o_out_ch.status       = w_out_status;
    assign o_out_ch.entry_offset = w_out_offset;
    assign o_out_ch.entry_size   = w_out_size;

endmodule

// File: rtl/core/mqaa_dpath.sv
`timescale 1ns / 1ps
module mqaa_dpath import mqaa_pkg::*; #(
    parameter int ARENA_BYTES = 65536,
    parameter int RING_SLOTS  = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_act        i_act,
    input  t_cfg_wr     i_cfg,
    input  logic        i_in_op,
    input  logic [15:0] i_in_len,
    input  logic        i_out_ready,
    output t_dp_stat    o_stat,
    output logic [7:0]  o_cap,
    output logic        o_out_valid,
    output logic [1:0]  o_out_status,
    output logic [15:0] o_out_offset,
    output logic [15:0] o_out_size
);

    localparam int WORDS = ARENA_BYTES / 4;
    localparam int AW    = $clog2(WORDS);
    localparam int OW    = AW + 2;
    localparam int RW    = (RING_SLOTS > 1) ? $clog2(RING_SLOTS) : 1;
    localparam int LW    = (RW + 1 > 9) ? RW + 1 : 9;
    localparam logic [OW-1:0] END_OFF = OW'(ARENA_BYTES - 4);

    function automatic logic [15:0] lo16(input logic [OW-1:0] x);
        logic [31:0] t;
        t = 32'(x);
        return t[15:0];
    endfunction

    logic [31:0] arena_mem [WORDS];
    logic [OW-1:0] slot_mem [RING_SLOTS];

    logic          r_op, n_op;
    logic [16:0]   r_req, n_req;
    logic [OW-1:0] r_cur, n_cur;
    logic [OW-1:0] r_prev, n_prev;
    logic          r_hp, n_hp;
    logic [OW-1:0] r_free_head, n_free_head;
    logic [OW-1:0] r_first, n_first;
    logic [OW-1:0] r_second, n_second;
    logic [31:0]   r_sz1, n_sz1;
    logic [31:0]   r_sz2, n_sz2;
    logic [OW-1:0] r_got, n_got;
    logic [15:0]   r_res_off, n_res_off;
    logic [15:0]   r_res_size, n_res_size;
    t_status       r_status, n_status;
    logic [RW-1:0] r_head, n_head;
    logic [RW-1:0] r_tail, n_tail;
    logic [7:0]    r_cap, n_cap;
    logic          r_out_valid, n_out_valid;
    t_status       r_out_status, n_out_status;
    logic [15:0]   r_out_off, n_out_off;
    logic [15:0]   r_out_size, n_out_size;
    logic [31:0]   r_ard;
    logic [OW-1:0] r_srd;

    logic          mem_we, mem_re;
    logic [AW-1:0] mem_addr;
    logic [31:0]   mem_wdata;
    logic          slot_we, slot_re;
    logic [RW-1:0] slot_addr;

    logic [31:0]   ard_mag, nx_mag, split_rem;
    logic [32:0]   nsum;
    logic [OW-1:0] nxt, nb;
    logic          nxt_end;
    logic [AW-1:0] cur_w;
    logic [LW-1:0] cap1, ring_len, t1, h1;
    logic [RW-1:0] tail_nxt, head_nxt;
    logic [16:0]   req_in;

    assign ard_mag   = r_ard[31] ? (32'd0 - r_ard) : r_ard;
    assign nx_mag    = r_op ? r_sz1 : ard_mag;
    // physical successor, clamped to the end marker
    assign nsum      = 33'(r_cur) + 33'(HDR_BYTES) + 33'(nx_mag);
    assign nxt       = (nsum > 33'(END_OFF)) ? END_OFF : nsum[OW-1:0];
    assign nxt_end   = (nxt == END_OFF);
    assign split_rem = r_sz1 - 32'(r_req);
    assign nb        = OW'(32'(r_cur) + split_rem);
    assign cur_w     = r_cur[OW-1:2];
    assign req_in    = (17'(i_in_len) + 17'd4) & ~17'd3;

    assign cap1     = LW'(r_cap) + LW'(1);
    assign ring_len = (cap1 > LW'(RING_SLOTS)) ? LW'(RING_SLOTS) : cap1;
    assign t1       = LW'(r_tail) + LW'(1);
    assign h1       = LW'(r_head) + LW'(1);
    assign tail_nxt = (t1 == ring_len) ? '0 : t1[RW-1:0];
    assign head_nxt = (h1 == ring_len) ? '0 : h1[RW-1:0];

    always_comb begin
        o_stat.is_deq   = r_op;
        o_stat.full     = (tail_nxt == r_head);
        o_stat.empty    = (r_head == r_tail);
        o_stat.too_big  = (r_req > MAX_ENTRY);
        o_stat.cur_end  = (r_cur == END_OFF);
        o_stat.fits     = (ard_mag >= 32'(r_req));
        o_stat.nxt_end  = nxt_end;
        o_stat.cand     = (r_ard != 32'd0) && r_ard[31];
        o_stat.hit      = (r_cur == r_second);
        o_stat.split    = (split_rem >= MIN_SPLIT);
        o_stat.out_busy = r_out_valid && !i_out_ready;
    end

    always_comb begin
        n_op = r_op;  n_req = r_req;  n_cur = r_cur;  n_prev = r_prev;  n_hp = r_hp;
        n_free_head = r_free_head;  n_first = r_first;  n_second = r_second;
        n_sz1 = r_sz1;  n_sz2 = r_sz2;  n_got = r_got;
        n_res_off = r_res_off;  n_res_size = r_res_size;  n_status = r_status;
        n_head = r_head;  n_tail = r_tail;  n_cap = r_cap;
        n_out_valid = r_out_valid;  n_out_status = r_out_status;
        n_out_off = r_out_off;  n_out_size = r_out_size;
        mem_we = 1'b0;  mem_re = 1'b0;  mem_addr = cur_w;  mem_wdata = 32'd0;
        slot_we = 1'b0;  slot_re = 1'b0;  slot_addr = r_tail;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (i_act)
            A_INIT_HDR: begin
                mem_we    = 1'b1;
                mem_addr  = '0;
                mem_wdata = 32'd0 - (32'(END_OFF) - HDR_BYTES);
            end
            A_INIT_LNK: begin
                mem_we    = 1'b1;
                mem_addr  = AW'(1);
                mem_wdata = 32'(END_OFF);
            end
            A_INIT_END: begin
                mem_we   = 1'b1;
                mem_addr = END_OFF[OW-1:2];
            end
            A_ACCEPT: begin
                n_op       = i_in_op;
                n_req      = req_in;
                n_status   = ST_OK;
                n_res_off  = 16'd0;
                n_res_size = 16'd0;
            end
            A_WALK_START: begin
                n_cur = r_free_head;
                n_hp  = 1'b0;
            end
            A_RD_SIZE: mem_re = 1'b1;
            A_FIT_SZ: begin
                if (ard_mag >= 32'(r_req)) begin
                    n_sz1 = ard_mag;
                end else begin
                    n_prev   = r_cur;
                    n_hp     = 1'b1;
                    mem_re   = 1'b1;
                    mem_addr = cur_w + AW'(1);
                end
            end
            A_LOAD_CUR: n_cur = r_ard[OW-1:0];
            A_MRG_SZ: begin
                n_sz1    = ard_mag;
                n_first  = r_cur;
                n_second = nxt;
                mem_re   = 1'b1;
                mem_addr = nxt_end ? (cur_w + AW'(1)) : nxt[OW-1:2];
            end
            A_MRG_NX: begin
                if (o_stat.cand) begin
                    n_sz2 = ard_mag;
                end else begin
                    mem_re   = 1'b1;
                    mem_addr = cur_w + AW'(1);
                end
            end
            A_UNL_CHK: begin
                mem_re   = 1'b1;
                mem_addr = cur_w + AW'(1);
                if (r_cur != r_second) begin
                    n_prev = r_cur;
                    n_hp   = 1'b1;
                end
            end
            A_RELINK: begin
                if (r_hp) begin
                    mem_we    = 1'b1;
                    mem_addr  = r_prev[OW-1:2] + AW'(1);
                    mem_wdata = r_ard;
                end else begin
                    n_free_head = r_ard[OW-1:0];
                end
            end
            A_MRG_WR: begin
                mem_we    = 1'b1;
                mem_addr  = r_first[OW-1:2];
                mem_wdata = 32'd0 - (r_sz1 + r_sz2 + HDR_BYTES);
            end
            A_SPLIT1: begin
                mem_we     = 1'b1;
                mem_addr   = nb[OW-1:2];
                mem_wdata  = 32'(r_req);
                n_got      = nb;
                n_res_size = r_req[15:0];
            end
            A_SPLIT2: begin
                mem_we    = 1'b1;
                mem_wdata = 32'd0 - (split_rem - HDR_BYTES);
            end
            A_TAKE_RD: begin
                mem_re   = 1'b1;
                mem_addr = cur_w + AW'(1);
            end
            A_TAKE_WR: begin
                mem_we     = 1'b1;
                mem_wdata  = r_sz1;
                n_got      = r_cur;
                n_res_size = r_sz1[15:0];
            end
            A_PUSH: begin
                slot_we   = 1'b1;
                n_tail    = tail_nxt;
                n_res_off = lo16(r_got);
            end
            A_REFUSE: n_status = r_op ? ST_EMPTY : ST_FULL;
            A_OOM: n_status = ST_OOM;
            A_DQ_SLOT_RD: begin
                slot_re   = 1'b1;
                slot_addr = r_head;
            end
            A_DQ_LOADOFF: begin
                n_cur    = r_srd;
                mem_re   = 1'b1;
                mem_addr = r_srd[OW-1:2];
            end
            A_DQ_SZ: begin
                n_sz1      = ard_mag;
                n_res_size = ard_mag[15:0];
                n_res_off  = lo16(r_cur);
                mem_we     = 1'b1;
                mem_wdata  = 32'd0 - ard_mag;
            end
            A_DQ_LNK: begin
                mem_we      = 1'b1;
                mem_addr    = cur_w + AW'(1);
                mem_wdata   = 32'(r_free_head);
                n_free_head = r_cur;
                n_head      = head_nxt;
            end
            A_DQ_NXT: begin
                n_first  = r_cur;
                n_second = nxt;
                mem_re   = !nxt_end;
                mem_addr = nxt[OW-1:2];
            end
            A_DQ_NXR: begin
                if (o_stat.cand) begin
                    n_sz2 = ard_mag;
                end
            end
            A_FIN: begin
                n_out_valid  = 1'b1;
                n_out_status = r_status;
                n_out_off    = r_res_off;
                n_out_size   = r_res_size;
            end
            default: ;
        endcase

        // capacity write also empties the ring
        if (i_cfg.we) begin
            n_cap  = i_cfg.cap;
            n_head = '0;
            n_tail = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            arena_mem[mem_addr] <= mem_wdata;
        end
        if (mem_re) begin
            r_ard <= arena_mem[mem_addr];
        end
        if (slot_we) begin
            slot_mem[slot_addr] <= r_got;
        end
        if (slot_re) begin
            r_srd <= slot_mem[slot_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free_head <= '0;
            r_head      <= '0;
            r_tail      <= '0;
            r_cap       <= 8'd255;
            r_out_valid <= 1'b0;
            r_op        <= 1'b0;
            r_hp        <= 1'b0;
            r_status    <= ST_OK;
        end else begin
            r_free_head <= n_free_head;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_cap       <= n_cap;
            r_out_valid <= n_out_valid;
            r_op        <= n_op;
            r_hp        <= n_hp;
            r_status    <= n_status;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req        <= n_req;
        r_cur        <= n_cur;
        r_prev       <= n_prev;
        r_first      <= n_first;
        r_second     <= n_second;
        r_sz1        <= n_sz1;
        r_sz2        <= n_sz2;
        r_got        <= n_got;
        r_res_off    <= n_res_off;
        r_res_size   <= n_res_size;
        r_out_status <= n_out_status;
        r_out_off    <= n_out_off;
        r_out_size   <= n_out_size;
    end

    assign o_cap        = r_cap;
    assign o_out_valid  = r_out_valid;
    assign o_out_status = r_out_status;
    assign o_out_offset = r_out_off;
    assign o_out_size   = r_out_size;

    a_ring_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (LW'(r_head) < ring_len) && (LW'(r_tail) < ring_len))
        else $error("ring pointer beyond ring length");

    a_size_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_size[1:0] == 2'b00))
        else $error("entry size not word aligned");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_status != ST_OK)) |-> ((r_out_off == 16'd0) &&
        (r_out_size == 16'd0)))
        else $error("refused transaction carries offset or size");

    a_head_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free_head[1:0] == 2'b00)
        else $error("free list head not word aligned");

endmodule

// File: rtl/core/mqaa_ctrl.sv
`timescale 1ns / 1ps
module mqaa_ctrl import mqaa_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  t_dp_stat i_stat,
    output logic     o_in_ready,
    output t_act     o_act
);

    typedef enum logic [28:0] {
        S_INIT0     = 29'(1) << 0,
        S_INIT1     = 29'(1) << 1,
        S_INIT2     = 29'(1) << 2,
        S_IDLE      = 29'(1) << 3,
        S_CHECK     = 29'(1) << 4,
        S_FIT_START = 29'(1) << 5,
        S_FIT_CHK   = 29'(1) << 6,
        S_FIT_SZ    = 29'(1) << 7,
        S_FIT_LNK   = 29'(1) << 8,
        S_MRG_CHK   = 29'(1) << 9,
        S_MRG_SZ    = 29'(1) << 10,
        S_MRG_NX    = 29'(1) << 11,
        S_MRG_LNK   = 29'(1) << 12,
        S_UNL_START = 29'(1) << 13,
        S_UNL_CHK   = 29'(1) << 14,
        S_UNL_LNK   = 29'(1) << 15,
        S_UNL_HIT   = 29'(1) << 16,
        S_MRG_WR    = 29'(1) << 17,
        S_ALLOC     = 29'(1) << 18,
        S_SPLIT2    = 29'(1) << 19,
        S_TAKE_LNK  = 29'(1) << 20,
        S_TAKE_WR   = 29'(1) << 21,
        S_PUSH      = 29'(1) << 22,
        S_DQ_SLOT   = 29'(1) << 23,
        S_DQ_SZ     = 29'(1) << 24,
        S_DQ_LNK    = 29'(1) << 25,
        S_DQ_NXT    = 29'(1) << 26,
        S_DQ_NXR    = 29'(1) << 27,
        S_FIN       = 29'(1) << 28
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state    = r_state;
        o_act      = A_NONE;
        o_in_ready = 1'b0;
        case (r_state)
            S_INIT0: begin
                o_act   = A_INIT_HDR;
                n_state = S_INIT1;
            end
            S_INIT1: begin
                o_act   = A_INIT_LNK;
                n_state = S_INIT2;
            end
            S_INIT2: begin
                o_act   = A_INIT_END;
                n_state = S_IDLE;
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_act   = A_ACCEPT;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_stat.is_deq) begin
                    if (i_stat.empty) begin
                        o_act   = A_REFUSE;
                        n_state = S_FIN;
                    end else begin
                        o_act   = A_DQ_SLOT_RD;
                        n_state = S_DQ_SLOT;
                    end
                end else if (i_stat.full) begin
                    o_act   = A_REFUSE;
                    n_state = S_FIN;
                end else if (i_stat.too_big) begin
                    o_act   = A_OOM;
                    n_state = S_FIN;
                end else begin
                    o_act   = A_WALK_START;
                    n_state = S_FIT_CHK;
                end
            end
            S_FIT_START: begin
                o_act   = A_WALK_START;
                n_state = S_FIT_CHK;
            end
            S_FIT_CHK: begin
                if (i_stat.cur_end) begin
                    o_act   = A_WALK_START;
                    n_state = S_MRG_CHK;
                end else begin
                    o_act   = A_RD_SIZE;
                    n_state = S_FIT_SZ;
                end
            end
            S_FIT_SZ: begin
                o_act   = A_FIT_SZ;
                n_state = i_stat.fits ? S_ALLOC : S_FIT_LNK;
            end
            S_FIT_LNK: begin
                o_act   = A_LOAD_CUR;
                n_state = S_FIT_CHK;
            end
            S_MRG_CHK: begin
                if (i_stat.cur_end) begin
                    o_act   = A_OOM;
                    n_state = S_FIN;
                end else begin
                    o_act   = A_RD_SIZE;
                    n_state = S_MRG_SZ;
                end
            end
            S_MRG_SZ: begin
                o_act   = A_MRG_SZ;
                n_state = i_stat.nxt_end ? S_MRG_LNK : S_MRG_NX;
            end
            S_MRG_NX: begin
                o_act   = A_MRG_NX;
                n_state = i_stat.cand ? S_UNL_START : S_MRG_LNK;
            end
            S_MRG_LNK: begin
                o_act   = A_LOAD_CUR;
                n_state = S_MRG_CHK;
            end
            S_UNL_START: begin
                o_act   = A_WALK_START;
                n_state = S_UNL_CHK;
            end
            S_UNL_CHK: begin
                if (i_stat.cur_end) begin
                    n_state = i_stat.is_deq ? S_FIN : S_FIT_START;
                end else begin
                    o_act   = A_UNL_CHK;
                    n_state = i_stat.hit ? S_UNL_HIT : S_UNL_LNK;
                end
            end
            S_UNL_LNK: begin
                o_act   = A_LOAD_CUR;
                n_state = S_UNL_CHK;
            end
            S_UNL_HIT: begin
                o_act   = A_RELINK;
                n_state = S_MRG_WR;
            end
            S_MRG_WR: begin
                o_act   = A_MRG_WR;
                n_state = i_stat.is_deq ? S_FIN : S_FIT_START;
            end
            S_ALLOC: begin
                if (i_stat.split) begin
                    o_act   = A_SPLIT1;
                    n_state = S_SPLIT2;
                end else begin
                    o_act   = A_TAKE_RD;
                    n_state = S_TAKE_LNK;
                end
            end
            S_SPLIT2: begin
                o_act   = A_SPLIT2;
                n_state = S_PUSH;
            end
            S_TAKE_LNK: begin
                o_act   = A_RELINK;
                n_state = S_TAKE_WR;
            end
            S_TAKE_WR: begin
                o_act   = A_TAKE_WR;
                n_state = S_PUSH;
            end
            S_PUSH: begin
                o_act   = A_PUSH;
                n_state = S_FIN;
            end
            S_DQ_SLOT: begin
                o_act   = A_DQ_LOADOFF;
                n_state = S_DQ_SZ;
            end
            S_DQ_SZ: begin
                o_act   = A_DQ_SZ;
                n_state = S_DQ_LNK;
            end
            S_DQ_LNK: begin
                o_act   = A_DQ_LNK;
                n_state = S_DQ_NXT;
            end
            S_DQ_NXT: begin
                o_act   = A_DQ_NXT;
                n_state = i_stat.nxt_end ? S_FIN : S_DQ_NXR;
            end
            S_DQ_NXR: begin
                o_act   = A_DQ_NXR;
                n_state = i_stat.cand ? S_UNL_START : S_FIN;
            end
            S_FIN: begin
                if (!i_stat.out_busy) begin
                    o_act   = A_FIN;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT0;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
